/* rtl/mbrs_pkg.sv */
// ----------------------------------------------------------------------------
// Modbus read-register slave package
// Shared types, constants and the fixed register image.
// ----------------------------------------------------------------------------
`default_nettype none
package mbrs_pkg;
   localparam int IMAGE_WORDS = 52;
   localparam logic [7:0] FC_READ = 8'h03;
   localparam logic [7:0] EXC_FLAG = 8'h80;
   localparam logic [7:0] EXC_FUNCTION = 8'h01;
   localparam logic [7:0] EXC_RANGE = 8'h02;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [7:0] UNIT_WORD = 8'd23;

   typedef enum logic [1:0] {
      JOB_READ = 2'd0,
      JOB_EXC_FUNCTION = 2'd1,
      JOB_EXC_RANGE = 2'd2
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0] unit;
      logic [7:0] fc;
      logic [7:0] addr;
      logic [7:0] qty;
   } job_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [15:0] image_word(input logic [7:0] idx);
      logic [15:0] w;
      case (idx)
         8'd0: w = 16'h000B;  8'd1: w = 16'h0034;  8'd2: w = 16'h0000;  8'd3: w = 16'h0001;
         8'd4: w = 16'hC200;  8'd5: w = 16'h0000;  8'd6: w = 16'h4545;  8'd7: w = 16'h4D34;
         8'd8: w = 16'h3030;  8'd9: w = 16'h2D2D;  8'd10: w = 16'h442D; 8'd11: w = 16'h4D4F;
         8'd12: w = 16'h2020; 8'd13: w = 16'h2020; 8'd14: w = 16'h000B; 8'd15: w = 16'h0001;
         8'd16: w = 16'h2345; 8'd17: w = 16'h0067; 8'd22: w = 16'h03E8;
         8'd27: w = 16'h000D; 8'd28: w = 16'hEBDF; 8'd29: w = 16'h000D; 8'd30: w = 16'hEBDF;
         8'd31: w = 16'h0007; 8'd32: w = 16'hA120; 8'd33: w = 16'h0001; 8'd34: w = 16'h86A0;
         8'd35: w = 16'h00E6; 8'd36: w = 16'h0034; 8'd37: w = 16'h0078; 8'd38: w = 16'h0032;
         8'd39: w = 16'h005F; 8'd40: w = 16'h00E7; 8'd41: w = 16'h0032; 8'd42: w = 16'h006E;
         8'd43: w = 16'h0032; 8'd44: w = 16'h0060; 8'd45: w = 16'h00E5; 8'd46: w = 16'h0030;
         8'd47: w = 16'h0064; 8'd48: w = 16'h0032; 8'd49: w = 16'h005E; 8'd50: w = 16'h014A;
         8'd51: w = 16'h0096;
         default: w = 16'h0000;
      endcase
      return w;
   endfunction
endpackage
`default_nettype wire

/* rtl/mbrs_front.sv */
// ----------------------------------------------------------------------------
// Modbus request front end
// Collects bytes in a sliding window, checks the CRC one byte per cycle and
// classifies each valid frame for this unit into a reply job.
// ----------------------------------------------------------------------------
`default_nettype none
module mbrs_front #(
   parameter int MAP_WORDS = 52,
   parameter int MAX_QUANTITY = 20
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic [7:0] unit_address,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic req_action,
   input wire logic [7:0] req_rx_byte,
   output logic job_valid,
   input wire logic job_ready,
   output mbrs_pkg::job_type job
);
   import mbrs_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_CRC, S_PUSH} state_type;

   state_type state_ff;
   logic [7:0] win_ff [8];
   logic [3:0] fill_ff;
   logic [2:0] k_ff;
   logic [15:0] crc_ff;
   job_type job_ff;

   logic [16:0] sum;
   logic [15:0] qty16;
   logic [15:0] addr16;
   logic [15:0] crc_next;

   assign req_ready = (state_ff == S_IDLE);
   assign job_valid = (state_ff == S_PUSH);
   assign job = job_ff;
   assign addr16 = {win_ff[2], win_ff[3]};
   assign qty16 = {win_ff[4], win_ff[5]};
   assign sum = {1'b0, addr16} + {1'b0, qty16};
   assign crc_next = crc_byte(crc_ff, win_ff[k_ff]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff <= 4'd0;
         for (int i = 0; i < 8; i++) win_ff[i] <= 8'h00;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  if (req_action) begin
                     fill_ff <= 4'd0;
                     for (int i = 0; i < 8; i++) win_ff[i] <= 8'h00;
                  end else begin
                     if (fill_ff < 4'd8) begin
                        win_ff[fill_ff[2:0]] <= req_rx_byte;
                        fill_ff <= fill_ff + 4'd1;
                     end else begin
                        for (int i = 0; i < 7; i++) win_ff[i] <= win_ff[i + 1];
                        win_ff[7] <= req_rx_byte;
                     end
                     if (fill_ff >= 4'd7) begin
                        state_ff <= S_CRC;
                        k_ff <= 3'd0;
                        crc_ff <= CRC_INIT;
                     end
                  end
               end
            end
            S_CRC: begin
               if (k_ff == 3'd6) begin
                  state_ff <= S_IDLE;
                  if (crc_ff == {win_ff[7], win_ff[6]}) begin
                     fill_ff <= 4'd0;
                     if (win_ff[0] == unit_address) begin
                        state_ff <= S_PUSH;
                        job_ff.unit <= win_ff[0];
                        job_ff.fc <= win_ff[1];
                        job_ff.addr <= win_ff[3];
                        job_ff.qty <= win_ff[5];
                        if (win_ff[1] != FC_READ) begin
                           job_ff.kind <= JOB_EXC_FUNCTION;
                        end else if (qty16 == 16'd0 || qty16 > 16'(MAX_QUANTITY)
                                     || sum > 17'(MAP_WORDS)) begin
                           job_ff.kind <= JOB_EXC_RANGE;
                        end else begin
                           job_ff.kind <= JOB_READ;
                        end
                     end
                  end
               end else begin
                  crc_ff <= crc_next;
                  k_ff <= k_ff + 3'd1;
               end
            end
            S_PUSH: begin
               if (job_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

/* rtl/mbrs_queue.sv */
// ----------------------------------------------------------------------------
// Modbus job queue
// Two-entry queue between the front end and the reply generator.
// ----------------------------------------------------------------------------
`default_nettype none
module mbrs_queue (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire mbrs_pkg::job_type in_job,
   output logic out_valid,
   input wire logic out_ready,
   output mbrs_pkg::job_type out_job
);
   import mbrs_pkg::*;

   job_type slot_ff [2];
   logic rd_ff;
   logic wr_ff;
   logic [1:0] count_ff;
   logic push;
   logic pop;

   assign in_ready = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_job = slot_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= in_job;
      if (reset) begin
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

/* rtl/mbrs_back.sv */
// ----------------------------------------------------------------------------
// Modbus reply generator
// Emits one reply byte per transfer and folds each header and data byte into the running CRC.
// ----------------------------------------------------------------------------
`default_nettype none
module mbrs_back #(
   parameter int MAP_WORDS = 52
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic [7:0] unit_address,
   input wire logic job_valid,
   output logic job_ready,
   input wire mbrs_pkg::job_type job,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [7:0] rsp_tx_byte,
   output logic rsp_last_byte
);
   import mbrs_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_HEAD0, S_HEAD1, S_HEAD2, S_DATA, S_CRCLO, S_CRCHI
   } state_type;

   state_type state_ff;
   job_type job_ff;
   logic [15:0] crc_ff;
   logic [7:0] idx_ff;
   logic [7:0] left_ff;
   logic hi_ff;
   logic [7:0] byte_sel;
   logic [15:0] word;
   logic take;

   assign job_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff != S_IDLE);
   assign take = rsp_valid && rsp_ready;
   assign rsp_last_byte = (state_ff == S_CRCHI);
   assign rsp_tx_byte = byte_sel;

   always_comb begin
      if (idx_ff == UNIT_WORD) word = {8'h00, unit_address};
      else if (int'(idx_ff) < MAP_WORDS) word = image_word(idx_ff);
      else word = 16'h0000;
      case (state_ff)
         S_HEAD0: byte_sel = job_ff.unit;
         S_HEAD1: byte_sel = (job_ff.kind == JOB_READ) ? job_ff.fc : (job_ff.fc | EXC_FLAG);
         S_HEAD2: begin
            case (job_ff.kind)
               JOB_EXC_FUNCTION: byte_sel = EXC_FUNCTION;
               JOB_EXC_RANGE: byte_sel = EXC_RANGE;
               default: byte_sel = {job_ff.qty[6:0], 1'b0};
            endcase
         end
         S_DATA: byte_sel = hi_ff ? word[15:8] : word[7:0];
         S_CRCLO: byte_sel = crc_ff[7:0];
         S_CRCHI: byte_sel = crc_ff[15:8];
         default: byte_sel = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (job_valid) begin
                  job_ff <= job;
                  crc_ff <= CRC_INIT;
                  state_ff <= S_HEAD0;
               end
            end
            S_HEAD0, S_HEAD1: begin
               if (take) begin
                  crc_ff <= crc_byte(crc_ff, byte_sel);
                  state_ff <= (state_ff == S_HEAD0) ? S_HEAD1 : S_HEAD2;
               end
            end
            S_HEAD2: begin
               if (take) begin
                  crc_ff <= crc_byte(crc_ff, byte_sel);
                  idx_ff <= job_ff.addr;
                  left_ff <= job_ff.qty;
                  hi_ff <= 1'b1;
                  state_ff <= (job_ff.kind == JOB_READ) ? S_DATA : S_CRCLO;
               end
            end
            S_DATA: begin
               if (take) begin
                  crc_ff <= crc_byte(crc_ff, byte_sel);
                  hi_ff <= ~hi_ff;
                  if (!hi_ff) begin
                     idx_ff <= idx_ff + 8'd1;
                     left_ff <= left_ff - 8'd1;
                     if (left_ff == 8'd1) state_ff <= S_CRCLO;
                  end
               end
            end
            S_CRCLO: if (take) state_ff <= S_CRCHI;
            S_CRCHI: if (take) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

/* rtl/modbus_rtu_read_register_slave.sv */
// ----------------------------------------------------------------------------
// Modbus RTU read-holding-registers slave
// Byte-serial slave answering function 3 requests from a fixed register map.
//
// The req_ channel carries one received byte (req_action low) or a line
// silence mark (req_action high). The rsp_ channel returns reply bytes, one
// per transfer, with rsp_last_byte on the final CRC byte. csr_ writes the unit
// address, which resets to 1.
// Once the window holds eight bytes, the front end checks the CRC after each
// byte, one byte per cycle through a single CRC step, and takes no byte
// meanwhile; a byte that completes a frame for this unit also waits while
// the queue is full. A valid frame becomes a job in a two-entry queue. The
// reply generator emits one byte per cycle while the receiver takes them,
// 5 to 45 bytes per reply. The first byte is offered once the idle reply
// generator has taken the job from the queue. When the receiver stalls, the
// reply holds; the front end keeps taking bytes until a completed frame
// finds the queue full. Reset empties the window, the queue and any reply.
// ----------------------------------------------------------------------------
`default_nettype none
module modbus_rtu_read_register_slave #(
   parameter int MAP_WORDS = 52,
   parameter int MAX_QUANTITY = 20
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [7:0] csr_unit_address,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic req_action,
   input wire logic [7:0] req_rx_byte,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [7:0] rsp_tx_byte,
   output logic rsp_last_byte
);
   import mbrs_pkg::*;

   logic [7:0] unit_ff;
   logic fq_valid, fq_ready, qb_valid, qb_ready;
   job_type fq_job, qb_job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) unit_ff <= 8'd1;
      else if (csr_valid) unit_ff <= csr_unit_address;
   end

   mbrs_front #(.MAP_WORDS(MAP_WORDS), .MAX_QUANTITY(MAX_QUANTITY)) u_front (
      .clock(clock), .reset(reset), .unit_address(unit_ff),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_rx_byte(req_rx_byte),
      .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
   );

   mbrs_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(fq_valid), .in_ready(fq_ready), .in_job(fq_job),
      .out_valid(qb_valid), .out_ready(qb_ready), .out_job(qb_job)
   );

   mbrs_back #(.MAP_WORDS(MAP_WORDS)) u_back (
      .clock(clock), .reset(reset), .unit_address(unit_ff),
      .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_tx_byte(rsp_tx_byte), .rsp_last_byte(rsp_last_byte)
   );
endmodule
`default_nettype wire

/* test/reply_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reply checker for the Modbus read-register slave
// Watches the request, reply and unit address channels, predicts every reply
// byte from the received bytes, and compares each reply transfer in order.
// ----------------------------------------------------------------------------
module reply_checker #(
   parameter int MAP_WORDS = 52,
   parameter int MAX_QUANTITY = 20
) (
   input logic clock,
   input logic reset,
   input logic csr_valid,
   input logic csr_ready,
   input logic [7:0] csr_unit_address,
   input logic req_valid,
   input logic req_ready,
   input logic req_action,
   input logic [7:0] req_rx_byte,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [7:0] rsp_tx_byte,
   input logic rsp_last_byte,
   output int fail_count,
   output int pending
);
   import mbrs_pkg::*;

   localparam logic [0:51][15:0] METER = {
      16'h000B, 16'h0034, 16'h0000, 16'h0001, 16'hC200, 16'h0000, 16'h4545, 16'h4D34,
      16'h3030, 16'h2D2D, 16'h442D, 16'h4D4F, 16'h2020, 16'h2020, 16'h000B, 16'h0001,
      16'h2345, 16'h0067, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h03E8, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h000D, 16'hEBDF, 16'h000D, 16'hEBDF, 16'h0007,
      16'hA120, 16'h0001, 16'h86A0, 16'h00E6, 16'h0034, 16'h0078, 16'h0032, 16'h005F,
      16'h00E7, 16'h0032, 16'h006E, 16'h0032, 16'h0060, 16'h00E5, 16'h0030, 16'h0064,
      16'h0032, 16'h005E, 16'h014A, 16'h0096
   };

   logic [7:0] window [0:7];
   int fill;
   logic [7:0] unit_addr;
   logic [8:0] reply_bytes [$];

   assign pending = reply_bytes.size();

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] r;
      r = crc ^ {8'h00, b};
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
   endfunction

   function automatic logic [15:0] word_at(input int idx);
      if (idx == int'(UNIT_WORD)) return {8'h00, unit_addr};
      if (idx < 52) return METER[idx];
      return 16'h0000;
   endfunction

   task automatic queue_reply(input logic [7:0] body [0:44], input int len);
      logic [15:0] crc;
      crc = CRC_INIT;
      for (int i = 0; i < len; i++) begin
         crc = crc_step(crc, body[i]);
         reply_bytes.push_back({1'b0, body[i]});
      end
      reply_bytes.push_back({1'b0, crc[7:0]});
      reply_bytes.push_back({1'b1, crc[15:8]});
   endtask

   task automatic take_byte(input logic act, input logic [7:0] b);
      logic [15:0] crc;
      logic [7:0] body [0:44];
      logic [7:0] fc;
      logic [15:0] w;
      int addr;
      int qty;
      if (act) begin
         fill = 0;
         for (int i = 0; i < 8; i++) window[i] = 8'h00;
         return;
      end
      if (fill < 8) begin
         window[fill] = b;
         fill++;
      end else begin
         for (int i = 0; i < 7; i++) window[i] = window[i + 1];
         window[7] = b;
      end
      if (fill < 8) return;
      crc = CRC_INIT;
      for (int i = 0; i < 6; i++) crc = crc_step(crc, window[i]);
      if ({window[7], window[6]} != crc) return;
      fill = 0;
      if (window[0] != unit_addr) return;
      fc = window[1];
      addr = int'({window[2], window[3]});
      qty = int'({window[4], window[5]});
      body[0] = window[0];
      if (fc != FC_READ) begin
         body[1] = fc | EXC_FLAG;
         body[2] = EXC_FUNCTION;
         queue_reply(body, 3);
      end else if (qty < 1 || qty > MAX_QUANTITY || addr + qty > MAP_WORDS) begin
         body[1] = fc | EXC_FLAG;
         body[2] = EXC_RANGE;
         queue_reply(body, 3);
      end else begin
         body[1] = fc;
         body[2] = 8'(qty * 2);
         for (int i = 0; i < qty; i++) begin
            w = word_at(addr + i);
            body[3 + 2 * i] = w[15:8];
            body[4 + 2 * i] = w[7:0];
         end
         queue_reply(body, 3 + 2 * qty);
      end
   endtask

   always @(posedge clock) begin
      logic [8:0] want;
      if (reset) begin
         fill = 0;
         for (int i = 0; i < 8; i++) window[i] = 8'h00;
         unit_addr = 8'd1;
         reply_bytes.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) unit_addr = csr_unit_address;
         if (rsp_valid && rsp_ready) begin
            if (reply_bytes.size() == 0) begin
               if (fail_count < 10)
                  $display("Unexpected reply byte %02h last %0b", rsp_tx_byte, rsp_last_byte);
               fail_count <= fail_count + 1;
            end else begin
               want = reply_bytes.pop_front();
               if (want != {rsp_last_byte, rsp_tx_byte}) begin
                  if (fail_count < 10)
                     $display("Reply mismatch: expected byte %02h last %0b, got %02h last %0b",
                              want[7:0], want[8], rsp_tx_byte, rsp_last_byte);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) take_byte(req_action, req_rx_byte);
      end
   end
endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus read-register slave testbench
// Drives request frames, noise and silence under changing unit addresses and
// handshake pressure; the reply checker predicts and compares every reply.
// ----------------------------------------------------------------------------
module testbench;
   import mbrs_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [7:0] csr_unit_address = 8'h00;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_action = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_tx_byte;
   logic rsp_last_byte;
   int fail_count;
   int pending;
   int send_idle = 0;
   int recv_idle = 0;
   logic [7:0] unit_now = 8'd1;

   always #1 clock = ~clock;

   modbus_rtu_read_register_slave uut (.*);
   reply_checker u_checker (.*);

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle);

   task automatic put(input logic act, input logic [7:0] b);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic logic [15:0] frame_crc(input logic [7:0] f [0:5]);
      logic [15:0] c;
      c = CRC_INIT;
      for (int i = 0; i < 6; i++) begin
         c = c ^ {8'h00, f[i]};
         repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   task automatic put_frame(input logic [7:0] unit, input logic [7:0] fc,
                            input logic [15:0] addr, input logic [15:0] qty,
                            input int keep, input bit corrupt);
      logic [7:0] f [0:7];
      logic [15:0] c;
      f[0] = unit; f[1] = fc; f[2] = addr[15:8]; f[3] = addr[7:0];
      f[4] = qty[15:8]; f[5] = qty[7:0];
      c = frame_crc(f[0:5]);
      if (corrupt) c = c ^ (16'h1 << $urandom_range(15));
      f[6] = c[7:0]; f[7] = c[15:8];
      for (int i = 0; i < keep; i++) put(1'b0, f[i]);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_unit(input logic [7:0] v);
      csr_valid <= 1'b1;
      csr_unit_address <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      unit_now = v;
   endtask

   task automatic random_step();
      int r;
      logic [7:0] u;
      logic [7:0] fc;
      logic [15:0] addr;
      logic [15:0] qty;
      r = $urandom_range(99);
      u = ($urandom_range(99) < 80) ? unit_now : 8'($urandom);
      fc = ($urandom_range(99) < 85) ? FC_READ : 8'($urandom);
      addr = ($urandom_range(99) < 80) ? 16'($urandom_range(55)) : 16'($urandom);
      qty = ($urandom_range(99) < 85) ? 16'($urandom_range(22)) : 16'($urandom);
      if (r < 70) begin
         put_frame(u, fc, addr, qty, 8, $urandom_range(99) < 10);
      end else if (r < 80) begin
         put_frame(u, fc, addr, qty, $urandom_range(1, 7), 1'b0);
         put(1'b1, 8'($urandom));
      end else if (r < 90) begin
         repeat ($urandom_range(1, 4)) put(1'b0, 8'($urandom));
      end else begin
         put(1'b1, 8'($urandom));
      end
   endtask

   initial begin
      logic [7:0] units [0:5];
      units = '{8'd0, 8'd255, 8'd1, 8'($urandom), 8'($urandom), 8'd1};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      put_frame(8'd1, FC_READ, 16'd23, 16'd20, 8, 1'b0);
      put_frame(8'd1, 8'h04, 16'd0, 16'd1, 8, 1'b0);
      put(1'b1, 8'hFF);
      put_frame(8'd1, FC_READ, 16'd0, 16'd21, 8, 1'b0);
      for (int ph = 0; ph < 6; ph++) begin
         wait_idle();
         write_unit(units[ph]);
         send_idle = (ph < 2) ? 6 : (ph < 4) ? 68 : 0;
         recv_idle = (ph < 2) ? 68 : (ph < 4) ? 6 : 0;
         for (int s = 0; s < 8; s++) begin
            if (ph == 4 && s == 4) wait_idle();
            random_step();
         end
      end
      put_frame(unit_now, FC_READ, 16'd32, 16'd20, 8, 1'b0);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end
endmodule
